>>> src/hrbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbd_pkg
// shared types and constants of the http response body decoder
// ----------------------------------------------------------------------------
package hrbd_pkg;

    localparam int MAX_HEADERS_DEF = 32;

    typedef struct packed {
        logic        is_summary;
        logic [7:0]  body_byte;
        logic [9:0]  resp_status;
        logic        success;
        logic [31:0] body_length;
        logic        last_of_item;
    } t_result;

endpackage

>>> src/hrbd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrbd_in_if / hrbd_out_if
// valid/ready channels for received bytes and decoded results
// ----------------------------------------------------------------------------
interface hrbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;
    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface hrbd_out_if;
    logic        valid;
    logic        ready;
    logic        is_summary;
    logic [7:0]  body_byte;
    logic [9:0]  resp_status;
    logic        success;
    logic [31:0] body_length;
    logic        last_of_item;
    modport source (output valid, output is_summary, output body_byte, output resp_status,
                    output success, output body_length, output last_of_item, input ready);
    modport sink   (input valid, input is_summary, input body_byte, input resp_status,
                    input success, input body_length, input last_of_item, output ready);
endinterface

>>> src/http_response_body_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_body_decoder_unit
// streaming http/1.1 response parser with chunked / length body decoding
// ----------------------------------------------------------------------------
// i_in carries one response byte per transfer, final_byte marks the last one.
// o_out carries results: a body byte, or after the final byte a summary with
// status code, success and body length; last_of_item marks the last result
// of a byte. each accepted byte updates the parser state in the same cycle
// and pushes zero, one or two results into a four-entry result queue, whose
// head drives o_out from registers. throughput is one byte per cycle
// while the queue has room; it needs room for two results, so i_in.ready
// drops while three or more results wait.
// a stalled receiver fills the queue and then holds off input.
// reset (synchronous, active low) clears the parser and empties the queue;
// after a summary the parser returns to its reset state for the next response.
// ----------------------------------------------------------------------------
module http_response_body_decoder_unit #(
    parameter int MAX_HEADERS = hrbd_pkg::MAX_HEADERS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hrbd_in_if.sink    i_in,
    hrbd_out_if.source o_out
);

    typedef enum logic [3:0] {
        PH_ST_PRE, PH_ST_DIGITS, PH_ST_REST,
        PH_H_NAME, PH_H_OTHER, PH_CL_SKIP, PH_CL_VAL, PH_TE_SKIP, PH_TE_VAL,
        PH_BODY, PH_CK_SIZE, PH_CK_EXT, PH_CK_DATA, PH_CK_TAIL,
        PH_DONE, PH_DISCARD
    } t_phase;

    localparam logic [4:0]  MISMATCH   = 5'd31;
    localparam logic [31:0] HEADER_END = 32'h0D0A0D0A;
    localparam logic [7:0]  MAX_HDR    = 8'(MAX_HEADERS);

    function automatic logic [7:0] f_lower(input logic [7:0] c);
        f_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] f_cl_char(input logic [4:0] p);
        case (p)
            5'd0:  f_cl_char = "c";
            5'd1:  f_cl_char = "o";
            5'd2:  f_cl_char = "n";
            5'd3:  f_cl_char = "t";
            5'd4:  f_cl_char = "e";
            5'd5:  f_cl_char = "n";
            5'd6:  f_cl_char = "t";
            5'd7:  f_cl_char = "-";
            5'd8:  f_cl_char = "l";
            5'd9:  f_cl_char = "e";
            5'd10: f_cl_char = "n";
            5'd11: f_cl_char = "g";
            5'd12: f_cl_char = "t";
            5'd13: f_cl_char = "h";
            default: f_cl_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] f_te_char(input logic [4:0] p);
        case (p)
            5'd0:  f_te_char = "t";
            5'd1:  f_te_char = "r";
            5'd2:  f_te_char = "a";
            5'd3:  f_te_char = "n";
            5'd4:  f_te_char = "s";
            5'd5:  f_te_char = "f";
            5'd6:  f_te_char = "e";
            5'd7:  f_te_char = "r";
            5'd8:  f_te_char = "-";
            5'd9:  f_te_char = "e";
            5'd10: f_te_char = "n";
            5'd11: f_te_char = "c";
            5'd12: f_te_char = "o";
            5'd13: f_te_char = "d";
            5'd14: f_te_char = "i";
            5'd15: f_te_char = "n";
            5'd16: f_te_char = "g";
            default: f_te_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] f_ck_char(input logic [2:0] p);
        case (p)
            3'd0: f_ck_char = "c";
            3'd1: f_ck_char = "h";
            3'd2: f_ck_char = "u";
            3'd3: f_ck_char = "n";
            3'd4: f_ck_char = "k";
            3'd5: f_ck_char = "e";
            3'd6: f_ck_char = "d";
            default: f_ck_char = 8'h00;
        endcase
    endfunction

    t_phase      r_phase, n_phase;
    logic [31:0] r_recent, n_recent;
    logic [9:0]  r_status, n_status;
    logic [2:0]  r_digits, n_digits;
    logic [7:0]  r_lines, n_lines;
    logic [4:0]  r_cl_prog, n_cl_prog;
    logic [4:0]  r_te_prog, n_te_prog;
    logic [2:0]  r_ck_prog, n_ck_prog;
    logic        r_f_cl, n_f_cl;
    logic        r_f_te, n_f_te;
    logic        r_f_ck, n_f_ck;
    logic [31:0] r_decl, n_decl;
    logic [31:0] r_chunk, n_chunk;
    logic [31:0] r_emit, n_emit;

    hrbd_pkg::t_result r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    logic              w_acc, w_pop;
    logic              w_body, w_sum;
    hrbd_pkg::t_result w_res_b, w_res_s;
    logic [7:0]        c, lc;
    logic              line_end;
    logic [35:0]       dec_acc;
    logic [3:0]        hexv;
    logic              hexok;
    logic              skip_space;
    logic [1:0]        n_push;

    assign w_acc = i_in.valid && i_in.ready;
    assign w_pop = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt <= 3'd2);
    assign c  = i_in.data_byte;
    assign lc = f_lower(c);

    always_comb begin
        n_phase   = r_phase;
        n_recent  = {r_recent[23:0], c};
        n_status  = r_status;
        n_digits  = r_digits;
        n_lines   = r_lines;
        n_cl_prog = r_cl_prog;
        n_te_prog = r_te_prog;
        n_ck_prog = r_ck_prog;
        n_f_cl    = r_f_cl;
        n_f_te    = r_f_te;
        n_f_ck    = r_f_ck;
        n_decl    = r_decl;
        n_chunk   = r_chunk;
        n_emit    = r_emit;
        w_body    = 1'b0;
        skip_space = 1'b0;
        line_end  = (c == 8'h0A) && (r_recent[7:0] == 8'h0D);
        dec_acc   = {4'd0, r_decl} * 36'd10 + {28'd0, c - 8'd48};
        hexok     = 1'b1;
        hexv      = 4'd0;
        if (c >= "0" && c <= "9") begin
            hexv = 4'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            hexv = 4'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            hexv = 4'(c - "A" + 8'd10);
        end else begin
            hexok = 1'b0;
        end

        case (r_phase)
            PH_ST_PRE, PH_ST_DIGITS, PH_ST_REST: begin
                if (line_end) begin
                    if (r_phase != PH_ST_PRE && r_digits == 3'd3) begin
                        n_lines   = 8'd0;
                        n_cl_prog = 5'd0;
                        n_te_prog = 5'd0;
                        n_phase   = (MAX_HDR > 8'd0) ? PH_H_NAME : PH_H_OTHER;
                    end else begin
                        n_phase = PH_DISCARD;
                    end
                end else if (r_phase == PH_ST_PRE) begin
                    if (c == " ") n_phase = PH_ST_DIGITS;
                end else if (r_phase == PH_ST_DIGITS) begin
                    if (c >= "0" && c <= "9") begin
                        if (r_digits < 3'd3)
                            n_status = r_status * 10'd10 + 10'(c - "0");
                        if (r_digits < 3'd4) n_digits = r_digits + 3'd1;
                    end else begin
                        n_phase = PH_ST_REST;
                    end
                end
            end
            PH_H_NAME, PH_H_OTHER, PH_CL_SKIP, PH_CL_VAL, PH_TE_SKIP, PH_TE_VAL: begin
                if (n_recent == HEADER_END) begin
                    if (r_f_ck) begin
                        n_phase = PH_CK_SIZE;
                        n_chunk = 32'd0;
                    end else if (r_f_cl && r_decl == 32'd0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end else if (line_end) begin
                    n_lines   = (r_lines != 8'd255) ? r_lines + 8'd1 : r_lines;
                    n_cl_prog = 5'd0;
                    n_te_prog = 5'd0;
                    n_phase   = (n_lines < MAX_HDR) ? PH_H_NAME : PH_H_OTHER;
                end else begin
                    if ((r_phase == PH_CL_SKIP || r_phase == PH_TE_SKIP) && c == " ")
                        skip_space = 1'b1;
                    if (!skip_space) begin
                        if (r_phase == PH_H_NAME) begin
                            if (c == ":") begin
                                if (r_cl_prog == 5'd14 && !r_f_cl) begin
                                    n_f_cl  = 1'b1;
                                    n_decl  = 32'd0;
                                    n_phase = PH_CL_SKIP;
                                end else if (r_te_prog == 5'd17 && !r_f_te) begin
                                    n_f_te    = 1'b1;
                                    n_ck_prog = 3'd0;
                                    n_phase   = PH_TE_SKIP;
                                end else begin
                                    n_phase = PH_H_OTHER;
                                end
                            end else begin
                                n_cl_prog = (r_cl_prog < 5'd14 && lc == f_cl_char(r_cl_prog))
                                          ? r_cl_prog + 5'd1 : MISMATCH;
                                n_te_prog = (r_te_prog < 5'd17 && lc == f_te_char(r_te_prog))
                                          ? r_te_prog + 5'd1 : MISMATCH;
                            end
                        end else if (r_phase == PH_CL_SKIP || r_phase == PH_CL_VAL) begin
                            n_phase = PH_CL_VAL;
                            if (c >= "0" && c <= "9") begin
                                n_decl = (dec_acc[35:32] != 4'd0) ? 32'hFFFFFFFF
                                                                  : dec_acc[31:0];
                            end else begin
                                n_phase = PH_H_OTHER;
                            end
                        end else if (r_phase == PH_TE_SKIP || r_phase == PH_TE_VAL) begin
                            n_phase = PH_TE_VAL;
                            if (r_ck_prog < 3'd7 && lc == f_ck_char(r_ck_prog)) begin
                                n_ck_prog = r_ck_prog + 3'd1;
                                if (r_ck_prog == 3'd6) begin
                                    n_f_ck  = 1'b1;
                                    n_phase = PH_H_OTHER;
                                end
                            end else begin
                                n_phase = PH_H_OTHER;
                            end
                        end
                    end
                end
            end
            PH_BODY: begin
                w_body = 1'b1;
                if (r_emit != 32'hFFFFFFFF) n_emit = r_emit + 32'd1;
                if (r_f_cl && n_emit >= r_decl) n_phase = PH_DONE;
            end
            PH_CK_SIZE: begin
                if (hexok) begin
                    n_chunk = (r_chunk > 32'h0FFFFFFF) ? 32'hFFFFFFFF
                                                       : {r_chunk[27:0], hexv};
                end else begin
                    n_phase = PH_CK_EXT;
                end
            end
            PH_CK_EXT: begin
                if (line_end) n_phase = (r_chunk == 32'd0) ? PH_DONE : PH_CK_DATA;
            end
            PH_CK_DATA: begin
                w_body = 1'b1;
                if (r_emit != 32'hFFFFFFFF) n_emit = r_emit + 32'd1;
                n_chunk = r_chunk - 32'd1;
                if (n_chunk == 32'd0) begin
                    n_chunk = 32'd2;
                    n_phase = PH_CK_TAIL;
                end
            end
            PH_CK_TAIL: begin
                n_chunk = r_chunk - 32'd1;
                if (n_chunk == 32'd0) n_phase = PH_CK_SIZE;
            end
            default: begin
            end
        endcase

        w_sum = i_in.final_byte;

        w_res_b              = '0;
        w_res_b.body_byte    = c;
        w_res_b.last_of_item = !w_sum;

        w_res_s              = '0;
        w_res_s.is_summary   = 1'b1;
        w_res_s.resp_status  = (n_phase >= PH_H_NAME && n_phase != PH_DISCARD)
                             ? n_status : 10'd0;
        w_res_s.success      = (n_phase == PH_BODY || n_phase == PH_DONE);
        w_res_s.body_length  = n_emit;
        w_res_s.last_of_item = 1'b1;

        n_push = {1'b0, w_body} + {1'b0, w_sum};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ST_PRE;
            r_recent  <= '0;
            r_status  <= '0;
            r_digits  <= '0;
            r_lines   <= '0;
            r_cl_prog <= '0;
            r_te_prog <= '0;
            r_ck_prog <= '0;
            r_f_cl    <= 1'b0;
            r_f_te    <= 1'b0;
            r_f_ck    <= 1'b0;
            r_decl    <= '0;
            r_chunk   <= '0;
            r_emit    <= '0;
        end else if (w_acc) begin
            if (w_sum) begin
                r_phase   <= PH_ST_PRE;
                r_recent  <= '0;
                r_status  <= '0;
                r_digits  <= '0;
                r_lines   <= '0;
                r_cl_prog <= '0;
                r_te_prog <= '0;
                r_ck_prog <= '0;
                r_f_cl    <= 1'b0;
                r_f_te    <= 1'b0;
                r_f_ck    <= 1'b0;
                r_decl    <= '0;
                r_chunk   <= '0;
                r_emit    <= '0;
            end else begin
                r_phase   <= n_phase;
                r_recent  <= n_recent;
                r_status  <= n_status;
                r_digits  <= n_digits;
                r_lines   <= n_lines;
                r_cl_prog <= n_cl_prog;
                r_te_prog <= n_te_prog;
                r_ck_prog <= n_ck_prog;
                r_f_cl    <= n_f_cl;
                r_f_te    <= n_f_te;
                r_f_ck    <= n_f_ck;
                r_decl    <= n_decl;
                r_chunk   <= n_chunk;
                r_emit    <= n_emit;
            end
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_acc) begin
                if (w_body) begin
                    r_q[r_wp] <= w_res_b;
                    if (w_sum) r_q[r_wp + 2'd1] <= w_res_s;
                end else if (w_sum) begin
                    r_q[r_wp] <= w_res_s;
                end
                r_wp <= r_wp + (w_acc ? n_push : 2'd0);
            end
            if (w_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + (w_acc ? {1'b0, n_push} : 3'd0) - {2'd0, w_pop};
        end
    end

    assign o_out.valid        = (r_cnt != 3'd0);
    assign o_out.is_summary   = r_q[r_rp].is_summary;
    assign o_out.body_byte    = r_q[r_rp].body_byte;
    assign o_out.resp_status  = r_q[r_rp].resp_status;
    assign o_out.success      = r_q[r_rp].success;
    assign o_out.body_length  = r_q[r_rp].body_length;
    assign o_out.last_of_item = r_q[r_rp].last_of_item;

endmodule
